[hdl/gne_pkg.sv]
// Shared types and constants for the grid neighborhood enumerator.
// Defines the input and output word layouts and the configuration register indexes.
// No dependencies.
package gne_pkg;

	localparam int FLAT_W  = 30;
	localparam int COORD_W = 10;
	localparam int NODES_W = 11;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXES_USED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODES_AXIS0 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODES_AXIS1 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NODES_AXIS2 = 2'd3;

	typedef struct packed {
		logic               mode;
		logic [FLAT_W-1:0]  center_flat;
		logic [COORD_W-1:0] center_axis0;
		logic [COORD_W-1:0] center_axis1;
		logic [COORD_W-1:0] center_axis2;
		logic               radius;
	} in_word_t;

	typedef struct packed {
		logic [FLAT_W-1:0] neighbor_flat;
		logic              last;
	} out_word_t;

endpackage

[hdl/grid_neighborhood_enumerator_top.sv]
// Coordinate mode goes straight to the range setup; flat mode first runs three
// 30-bit divisions by the axis sizes, 2 quotient bits per cycle on one shared divider.
// During the walk the block emits one word per cycle while the output side does not stall,
// and the skipped centre takes a walk step that emits no word; a new request is taken
// only after the walk has ended.
// Reset (arst_n low, asynchronous): idle, output empty, axes_used 3, all node counts 1.
// Depends on gne_pkg.
module grid_neighborhood_enumerator_top
	import gne_pkg::*;
#(
	parameter int AXES               = 3,
	parameter int MAX_NODES_PER_AXIS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NODES_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_word
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_RANGE = 3'd2;
	localparam logic [2:0] S_BASE1 = 3'd3;
	localparam logic [2:0] S_BASE2 = 3'd4;
	localparam logic [2:0] S_WALK  = 3'd5;

	localparam int DIV_BITS_PER_CYC = 2;
	localparam int DIV_CYCLES       = FLAT_W / DIV_BITS_PER_CYC;
	localparam logic [3:0] DIV_LAST = 4'(DIV_CYCLES - 1);

	localparam logic [1:0]         AXES_MAX  = 2'(AXES);
	localparam logic [NODES_W-1:0] NODES_MAX = NODES_W'(MAX_NODES_PER_AXIS);

	// Configuration registers
	logic [1:0]         axes_used_q;
	logic [NODES_W-1:0] nodes_q [3];

	// Sequencer and datapath registers
	logic [2:0]         state_q;
	logic               radius_q;
	logic [1:0]         axis_q;
	logic [3:0]         div_cnt_q;
	logic [FLAT_W-1:0]  dvd_q;
	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] c_q  [3];
	logic [COORD_W-1:0] lo_q [3];
	logic [COORD_W-1:0] hi_q [3];
	logic [COORD_W-1:0] x_q  [3];
	logic [20:0]        s2_q;
	logic [FLAT_W-1:0]  acc_q;
	logic [FLAT_W-1:0]  f_q;
	logic [FLAT_W-1:0]  row_q;
	logic [FLAT_W-1:0]  plane_q;
	logic [4:0]         left_q;
	logic               out_valid_q;
	out_word_t          out_word_q;

	// Effective axis sizes
	logic [1:0]         axes_eff;
	logic [NODES_W-1:0] sz [3];

	always_comb begin
		axes_eff = (axes_used_q == 2'd0) ? 2'd1 : axes_used_q;
		if (axes_eff > AXES_MAX) begin
			axes_eff = AXES_MAX;
		end
		for (int k = 0; k < 3; k++) begin
			if (2'(k) >= axes_eff) begin
				sz[k] = NODES_W'(1);
			end else if (nodes_q[k] == '0) begin
				sz[k] = NODES_W'(1);
			end else if (nodes_q[k] > NODES_MAX) begin
				sz[k] = NODES_MAX;
			end else begin
				sz[k] = nodes_q[k];
			end
		end
	end

	// Divider: two restoring steps per cycle on the selected axis size
	logic [NODES_W-1:0] div_sz;
	logic [COORD_W-1:0] div_rem;
	logic [FLAT_W-1:0]  div_dvd;
	logic [NODES_W-1:0] div_trial;

	assign div_sz = sz[axis_q];

	always_comb begin
		div_rem = rem_q;
		div_dvd = dvd_q;
		div_trial = '0;
		for (int i = 0; i < DIV_BITS_PER_CYC; i++) begin
			div_trial = {div_rem, div_dvd[FLAT_W-1]};
			if (div_trial >= div_sz) begin
				div_trial = div_trial - div_sz;
				div_dvd = {div_dvd[FLAT_W-2:0], 1'b1};
			end else begin
				div_dvd = {div_dvd[FLAT_W-2:0], 1'b0};
			end
			div_rem = div_trial[COORD_W-1:0];
		end
	end

	// Clamp coordinates for coordinate mode
	logic [COORD_W-1:0] in_c [3];

	always_comb begin
		in_c[0] = in_word.center_axis0;
		in_c[1] = in_word.center_axis1;
		in_c[2] = in_word.center_axis2;
		for (int k = 0; k < 3; k++) begin
			if ({1'b0, in_c[k]} >= sz[k]) begin
				in_c[k] = COORD_W'(sz[k] - NODES_W'(1));
			end
		end
	end

	// Clip the neighborhood to the grid
	logic [COORD_W-1:0] lo_d [3];
	logic [COORD_W-1:0] hi_d [3];
	logic [NODES_W-1:0] c_plus_r;
	logic [NODES_W-1:0] sz_m1;

	always_comb begin
		c_plus_r = '0;
		sz_m1 = '0;
		for (int k = 0; k < 3; k++) begin
			lo_d[k] = (c_q[k] < COORD_W'(radius_q)) ? '0 : c_q[k] - COORD_W'(radius_q);
			c_plus_r = {1'b0, c_q[k]} + NODES_W'(radius_q);
			sz_m1 = sz[k] - NODES_W'(1);
			hi_d[k] = (c_plus_r > sz_m1) ? sz_m1[COORD_W-1:0] : c_plus_r[COORD_W-1:0];
		end
	end

	// Shared multiplier for the setup products
	logic [NODES_W-1:0] mul_a;
	logic [20:0]        mul_b;
	logic [31:0]        mul_p;

	always_comb begin
		case (state_q)
			S_RANGE: begin
				mul_a = sz[0];
				mul_b = 21'(sz[1]);
			end
			S_BASE1: begin
				mul_a = {1'b0, lo_q[2]};
				mul_b = s2_q;
			end
			S_BASE2: begin
				mul_a = sz[0];
				mul_b = 21'(lo_q[1]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 32'(mul_a) * 32'(mul_b);

	// Number of words: box volume less the centre
	logic [1:0] ext [3];
	logic [4:0] total;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ext[k] = 2'(hi_q[k] - lo_q[k]) + 2'd1;
		end
		total = 5'(ext[0]) * 5'(ext[1]) * 5'(ext[2]) - 5'd1;
	end

	// Walk control
	logic is_centre;
	logic load_out;
	logic walk_go;
	logic walk_done;
	logic [FLAT_W-1:0] base_sum;

	assign is_centre = (x_q[0] == c_q[0]) && (x_q[1] == c_q[1]) && (x_q[2] == c_q[2]);
	assign walk_go   = (state_q == S_WALK) && (is_centre || !out_valid_q || out_ready);
	assign load_out  = walk_go && !is_centre;
	assign walk_done = walk_go && (x_q[0] == hi_q[0]) && (x_q[1] == hi_q[1])
		&& (x_q[2] == hi_q[2]);
	assign base_sum  = acc_q + mul_p[FLAT_W-1:0] + FLAT_W'(lo_q[0]);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axes_used_q <= 2'd3;
			nodes_q[0] <= NODES_W'(1);
			nodes_q[1] <= NODES_W'(1);
			nodes_q[2] <= NODES_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_AXES_USED:   axes_used_q <= cfg_data[1:0];
				REG_NODES_AXIS0: nodes_q[0] <= cfg_data;
				REG_NODES_AXIS1: nodes_q[1] <= cfg_data;
				REG_NODES_AXIS2: nodes_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			axis_q <= '0;
			div_cnt_q <= '0;
			left_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						axis_q <= '0;
						div_cnt_q <= '0;
						state_q <= in_word.mode ? S_RANGE : S_DIV;
					end
				end
				S_DIV: begin
					if (div_cnt_q == DIV_LAST) begin
						div_cnt_q <= '0;
						if (axis_q == 2'd2) begin
							state_q <= S_RANGE;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						div_cnt_q <= div_cnt_q + 4'd1;
					end
				end
				S_RANGE: state_q <= S_BASE1;
				S_BASE1: state_q <= S_BASE2;
				S_BASE2: begin
					left_q <= total;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (load_out) begin
						left_q <= left_q - 5'd1;
					end
					if (walk_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				radius_q <= in_word.radius;
				dvd_q <= in_word.center_flat;
				rem_q <= '0;
				if (in_word.mode) begin
					c_q[0] <= in_c[0];
					c_q[1] <= in_c[1];
					c_q[2] <= in_c[2];
				end
			end
			S_DIV: begin
				dvd_q <= div_dvd;
				if (div_cnt_q == DIV_LAST) begin
					c_q[axis_q] <= div_rem;
					rem_q <= '0;
				end else begin
					rem_q <= div_rem;
				end
			end
			S_RANGE: begin
				for (int k = 0; k < 3; k++) begin
					lo_q[k] <= lo_d[k];
					hi_q[k] <= hi_d[k];
					x_q[k] <= lo_d[k];
				end
				s2_q <= mul_p[20:0];
			end
			S_BASE1: acc_q <= mul_p[FLAT_W-1:0];
			S_BASE2: begin
				f_q <= base_sum;
				row_q <= base_sum;
				plane_q <= base_sum;
			end
			S_WALK: begin
				if (walk_go) begin
					// Advance the odometer, axis 0 fastest
					if (x_q[0] != hi_q[0]) begin
						x_q[0] <= x_q[0] + COORD_W'(1);
						f_q <= f_q + FLAT_W'(1);
					end else if (x_q[1] != hi_q[1]) begin
						x_q[0] <= lo_q[0];
						x_q[1] <= x_q[1] + COORD_W'(1);
						row_q <= row_q + FLAT_W'(sz[0]);
						f_q <= row_q + FLAT_W'(sz[0]);
					end else if (x_q[2] != hi_q[2]) begin
						x_q[0] <= lo_q[0];
						x_q[1] <= lo_q[1];
						x_q[2] <= x_q[2] + COORD_W'(1);
						plane_q <= plane_q + FLAT_W'(s2_q);
						row_q <= plane_q + FLAT_W'(s2_q);
						f_q <= plane_q + FLAT_W'(s2_q);
					end
				end
			end
			default: ;
		endcase
		// Hold the output word until taken
		if (load_out) begin
			out_word_q.neighbor_flat <= f_q;
			out_word_q.last <= (left_q == 5'd1);
		end
	end

	// Divider remainder stays below the divisor
	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ({1'b0, rem_q} < div_sz))
		else $error("divider remainder not below axis size");

	// Every emitted word has budget left
	a_emit_budget: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (left_q != 5'd0))
		else $error("word emitted beyond neighborhood count");

	// Walk ends exactly when the count is spent
	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |=> (left_q == 5'd0))
		else $error("walk ended with words unaccounted");

	// Odometer stays at or below the box's upper corner, and the centre lies in the box on axis 0
	a_walk_box: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> ((x_q[0] <= hi_q[0]) && (x_q[1] <= hi_q[1])
			&& (x_q[2] <= hi_q[2]) && (lo_q[0] <= c_q[0]) && (c_q[0] <= hi_q[0])))
		else $error("odometer outside neighborhood box");

	// Last flag leaves at most the skipped centre behind it in the walk
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (left_q == 5'd1)) |=> (state_q == S_IDLE) || (is_centre && walk_done))
		else $error("last word not at end of walk");

endmodule

[tb/sv/tb_grid_neighborhood_enumerator_top.sv]
// Testbench for grid_neighborhood_enumerator_top: drives center requests, predicts every
// neighbor index in walk order and checks each output word against that prediction.
// Depends on gne_pkg and the grid_neighborhood_enumerator_top RTL.
`timescale 1ns / 1ps

module tb_grid_neighborhood_enumerator_top;
	import gne_pkg::*;

	localparam int AXES_N         = 3;
	localparam int MAX_NODES      = 1024;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_CHUNK   = 19;

	localparam logic MODE_FLAT  = 1'b0;
	localparam logic MODE_COORD = 1'b1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NODES_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	in_word_t             in_word;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_word;

	// Shadow copy of the grid registers
	logic [1:0]         grid_axes;
	logic [NODES_W-1:0] grid_nodes [3];

	out_word_t   expected_neighbors [$];
	out_word_t   want;
	int unsigned mismatch_count;
	int unsigned quiet_cycles = 0;
	int unsigned sender_gap_pct;
	int unsigned receiver_stall_pct;

	grid_neighborhood_enumerator_top #(
		.AXES               (AXES_N),
		.MAX_NODES_PER_AXIS (MAX_NODES)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always #5 clk = ~clk;

	// Effective node count of one axis after clamping and axis masking
	function automatic int unsigned axis_size(int k);
		int unsigned ax;
		int unsigned v;
		ax = (grid_axes == 0) ? 1 : grid_axes;
		if (ax > AXES_N) ax = AXES_N;
		if (k >= ax) return 1;
		v = grid_nodes[k];
		if (v == 0) v = 1;
		if (v > MAX_NODES) v = MAX_NODES;
		return v;
	endfunction

	// Walk the clipped neighborhood and queue every index except the center
	task automatic predict_neighbors(input in_word_t w);
		int unsigned     sz [3];
		int unsigned     c [3];
		int unsigned     lo [3];
		int unsigned     hi [3];
		int unsigned     r;
		longint unsigned v;
		longint unsigned s1;
		longint unsigned s2;
		longint unsigned center;
		longint unsigned f;
		longint unsigned found [$];
		out_word_t       o;
		for (int k = 0; k < 3; k++) sz[k] = axis_size(k);
		r = w.radius;
		if (w.mode == MODE_FLAT) begin
			v = w.center_flat;
			for (int k = 0; k < 3; k++) begin
				c[k] = 32'(v % sz[k]);
				v = v / sz[k];
			end
		end else begin
			c[0] = w.center_axis0;
			c[1] = w.center_axis1;
			c[2] = w.center_axis2;
			for (int k = 0; k < 3; k++) begin
				if (c[k] >= sz[k]) c[k] = sz[k] - 1;
			end
		end
		for (int k = 0; k < 3; k++) begin
			lo[k] = (c[k] < r) ? 0 : c[k] - r;
			hi[k] = (c[k] + r > sz[k] - 1) ? sz[k] - 1 : c[k] + r;
		end
		s1 = sz[0];
		s2 = longint'(sz[0]) * sz[1];
		center = c[0] + c[1] * s1 + c[2] * s2;
		for (int unsigned x2 = lo[2]; x2 <= hi[2]; x2++) begin
			for (int unsigned x1 = lo[1]; x1 <= hi[1]; x1++) begin
				for (int unsigned x0 = lo[0]; x0 <= hi[0]; x0++) begin
					f = x0 + x1 * s1 + x2 * s2;
					if (f != center) found.push_back(f);
				end
			end
		end
		for (int i = 0; i < found.size(); i++) begin
			o.neighbor_flat = found[i][FLAT_W-1:0];
			o.last = (i == found.size() - 1);
			expected_neighbors.push_back(o);
		end
	endtask

	// Build a request; fields of the unused mode carry random junk
	function automatic in_word_t make_request(logic mode, int unsigned flat, int unsigned a0,
		int unsigned a1, int unsigned a2, logic r);
		in_word_t w;
		w.mode = mode;
		w.radius = r;
		w.center_flat = FLAT_W'((mode == MODE_FLAT) ? flat : $urandom);
		w.center_axis0 = COORD_W'((mode == MODE_COORD) ? a0 : $urandom);
		w.center_axis1 = COORD_W'((mode == MODE_COORD) ? a1 : $urandom);
		w.center_axis2 = COORD_W'((mode == MODE_COORD) ? a2 : $urandom);
		return w;
	endfunction

	// Mostly in-grid centers with random content, the rest raw noise
	function automatic in_word_t random_request();
		in_word_t        w;
		longint unsigned total;
		w.mode = 1'($urandom_range(0, 1));
		w.center_flat = FLAT_W'($urandom);
		w.center_axis0 = COORD_W'($urandom);
		w.center_axis1 = COORD_W'($urandom);
		w.center_axis2 = COORD_W'($urandom);
		w.radius = ($urandom_range(0, 99) < 85);
		if ($urandom_range(0, 3) != 0) begin
			total = longint'(axis_size(0)) * axis_size(1) * axis_size(2);
			w.center_flat = FLAT_W'(longint'($urandom) % total);
			w.center_axis0 = COORD_W'($urandom_range(0, axis_size(0) - 1));
			w.center_axis1 = COORD_W'($urandom_range(0, axis_size(1) - 1));
			w.center_axis2 = COORD_W'($urandom_range(0, axis_size(2) - 1));
		end
		return w;
	endfunction

	// Send one word; returns at the falling edge after acceptance with valid still high
	task automatic send_word(input in_word_t w);
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		predict_neighbors(w);
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid, drain all expected words, then let a trailing walk finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_neighbors.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NODES_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_AXES_USED:   grid_axes = data[1:0];
			REG_NODES_AXIS0: grid_nodes[0] = data;
			REG_NODES_AXIS1: grid_nodes[1] = data;
			REG_NODES_AXIS2: grid_nodes[2] = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Reprogram the whole grid once the block is idle
	task automatic set_grid(input int unsigned axes, input int unsigned n0, input int unsigned n1,
		input int unsigned n2);
		wait_idle();
		write_reg(REG_AXES_USED, NODES_W'(axes));
		write_reg(REG_NODES_AXIS0, NODES_W'(n0));
		write_reg(REG_NODES_AXIS1, NODES_W'(n1));
		write_reg(REG_NODES_AXIS2, NODES_W'(n2));
		cfg_write <= 1'b0;
	endtask

	function automatic int unsigned random_node_count();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return ($urandom_range(0, 1) != 0) ? 2047 : MAX_NODES;
			2: return $urandom_range(0, 2047);
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	// Reset values give a single-node grid: nothing may come out
	task automatic test_single_node_grid();
		send_word(make_request(MODE_FLAT, 0, 0, 0, 0, 1'b1));
		send_word(make_request(MODE_FLAT, 30'h3FFF_FFFF, 0, 0, 0, 1'b1));
		send_word(make_request(MODE_COORD, 0, 1023, 1023, 1023, 1'b1));
		send_word(make_request(MODE_COORD, 0, 0, 0, 0, 1'b0));
	endtask

	// Full, corner and clipped cubes on a 3x3x3 grid
	task automatic test_cube_neighborhoods();
		set_grid(3, 3, 3, 3);
		send_word(make_request(MODE_COORD, 0, 1, 1, 1, 1'b1));
		send_word(make_request(MODE_COORD, 0, 0, 0, 0, 1'b1));
		send_word(make_request(MODE_COORD, 0, 2, 2, 2, 1'b1));
		send_word(make_request(MODE_COORD, 0, 1, 1, 1, 1'b0));
		send_word(make_request(MODE_FLAT, 13, 0, 0, 0, 1'b1));
		send_word(make_request(MODE_FLAT, 30'h3FFF_FFFF, 0, 0, 0, 1'b1));
		send_word(make_request(MODE_COORD, 0, 1023, 1023, 1023, 1'b1));
		send_word(make_request(MODE_FLAT, 5, 0, 0, 0, 1'b0));
	endtask

	// Zero axis count, zero and oversized node counts, unused axes, wrap of the last axis
	task automatic test_register_clamping();
		set_grid(0, MAX_NODES, 0, 2047);
		send_word(make_request(MODE_FLAT, 1023, 0, 0, 0, 1'b1));
		send_word(make_request(MODE_FLAT, 0, 0, 0, 0, 1'b1));
		send_word(make_request(MODE_COORD, 0, 512, 1023, 1023, 1'b1));
		send_word(make_request(MODE_FLAT, 30'h3FFF_FFFF, 0, 0, 0, 1'b1));
		set_grid(2, 2047, MAX_NODES, 5);
		send_word(make_request(MODE_COORD, 0, 1023, 1023, 7, 1'b1));
		send_word(make_request(MODE_FLAT, 1024 * 1024 - 1, 0, 0, 0, 1'b1));
		send_word(make_request(MODE_FLAT, 1024, 0, 0, 0, 1'b1));
		set_grid(3, MAX_NODES, MAX_NODES, MAX_NODES);
		send_word(make_request(MODE_FLAT, 30'h3FFF_FFFF, 0, 0, 0, 1'b1));
		send_word(make_request(MODE_COORD, 0, 0, 1023, 512, 1'b1));
		send_word(make_request(MODE_FLAT, 0, 0, 0, 0, 1'b1));
	endtask

	// Random grids and centers under each idling mix
	task automatic test_random_traffic();
		int unsigned gap_mix [4];
		int unsigned stall_mix [4];
		gap_mix = '{0, 46, 0, 14};
		stall_mix = '{0, 0, 46, 14};
		for (int p = 0; p < 4; p++) begin
			for (int half = 0; half < 2; half++) begin
				set_grid($urandom_range(0, 3), random_node_count(), random_node_count(),
					random_node_count());
				sender_gap_pct = gap_mix[p];
				receiver_stall_pct = stall_mix[p];
				repeat (RANDOM_CHUNK) send_word(random_request());
			end
		end
	endtask

	// Check each accepted output word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_neighbors.size() == 0) begin
				$display("%0t: unexpected word neighbor_flat=%0d last=%0b", $time,
					out_word.neighbor_flat, out_word.last);
				mismatch_count++;
			end else begin
				want = expected_neighbors.pop_front();
				if (out_word.neighbor_flat !== want.neighbor_flat) begin
					$display("%0t: neighbor_flat expected %0d actual %0d", $time,
						want.neighbor_flat, out_word.neighbor_flat);
					mismatch_count++;
				end
				if (out_word.last !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $time, want.last,
						out_word.last);
					mismatch_count++;
				end
			end
		end
	end

	// Stall the output side at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d words outstanding", $time,
				expected_neighbors.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		mismatch_count = 0;
		sender_gap_pct = 0;
		receiver_stall_pct = 0;
		grid_axes = 2'd3;
		grid_nodes[0] = 1;
		grid_nodes[1] = 1;
		grid_nodes[2] = 1;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_single_node_grid();
		test_cube_neighborhoods();
		test_register_clamping();
		test_random_traffic();

		wait_idle();
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[files.f]
hdl/gne_pkg.sv
hdl/grid_neighborhood_enumerator_top.sv
tb/sv/tb_grid_neighborhood_enumerator_top.sv
